// ===== design/oltkd_pkg.sv =====
// ----------------------------------------------------------------------------
// oltkd_pkg - shared types and codes for the ordered list unit
// Opcodes, result status codes, widths, and the command and status bundles
// that join the controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package oltkd_pkg;

   localparam int CAPACITY_DEF = 32;
   localparam int VALUE_W      = 32;
   localparam int OPCODE_W     = 2;
   localparam int STATUS_W     = 3;
   localparam int COUNT_W      = 6;

   localparam logic [OPCODE_W-1:0] OP_APPEND  = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_DELETE  = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_READOUT = 2'd2;

   localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_DELETED  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_ELEMENT  = 3'd4;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd5;

   typedef struct packed {
      logic                load;
      logic                scan_clr;
      logic                scan_inc;
      logic                append_wr;
      logic                walk_start;
      logic                walk_next;
      logic                unlink;
      logic                emit;
      logic                emit_last;
      logic [STATUS_W-1:0] emit_status;
   } cmd_type;

   typedef struct packed {
      logic count_zero;
      logic pool_full;
      logic slot_free;
      logic key_match;
      logic walk_end;
   } sts_type;

endpackage

`default_nettype wire

// ===== design/ordered_list_tail_insert_key_delete_unit.sv =====
// ----------------------------------------------------------------------------
// ordered_list_tail_insert_key_delete_unit - doubly linked list in a slot pool
// Appends values at the tail, deletes the first match of a key found from
// the head, and reads the whole list out from head to tail.
// ----------------------------------------------------------------------------
// Using the block: a command transfers at a clock edge where start is high
// and busy is low, and busy stays high until the command is finished. Results
// come out on the rsp_ ports for exactly one cycle each, marked by rsp_valid;
// the receiver cannot stall them, so it must take every strobe. The final
// result of a command carries rsp_last. A full append, a delete on an empty
// list and a read-out of an empty list give their single result straight from
// the decode state; an append first searches for the lowest free slot (the
// free slot search tests one occupancy bit per cycle); a delete walks from the
// head until it hits, and a miss walks all n stored elements; a read-out
// delivers one element per cycle. The list walks are set by the pool
// memories, which give one registered read per cycle. Each result appears the
// cycle after the cycle that produced it. Pool contents are not cleared at
// reset; only the slot occupancy bits, head, tail and count are.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_list_tail_insert_key_delete_unit #(
   parameter int CAPACITY = oltkd_pkg::CAPACITY_DEF
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    start,
   output logic                                         busy,
   input  wire logic        [oltkd_pkg::OPCODE_W-1:0]   req_opcode,
   input  wire logic signed [oltkd_pkg::VALUE_W-1:0]    req_item_value,
   output logic                                         rsp_valid,
   output logic             [oltkd_pkg::STATUS_W-1:0]   rsp_status,
   output logic signed      [oltkd_pkg::VALUE_W-1:0]    rsp_result_value,
   output logic                                         rsp_last,
   output logic             [oltkd_pkg::COUNT_W-1:0]    rsp_entry_count
);

   oltkd_pkg::cmd_type cmd;
   oltkd_pkg::sts_type sts;

   // sequence each command; the datapath only acts on these strobes
   oltkd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_opcode (req_opcode),
      .sts        (sts),
      .cmd        (cmd),
      .busy       (busy)
   );

   // hold list storage, pointers and the result register
   oltkd_dp #(.CAPACITY(CAPACITY)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .item_value       (req_item_value),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_result_value (rsp_result_value),
      .rsp_last         (rsp_last),
      .rsp_entry_count  (rsp_entry_count)
   );

`ifndef NO_ASSERTIONS
   // an accepted command always raises busy in the following cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted command did not raise busy");

   // the final result of a command goes out as the block returns to idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> !busy)
      else $error("final result while still busy");

   // read-out elements stream back to back until the last one
   a_readout_stream: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last && rsp_status == oltkd_pkg::ST_ELEMENT
      |=> rsp_valid && rsp_status == oltkd_pkg::ST_ELEMENT)
      else $error("gap in read-out stream");

   // a successful insert always leaves at least one element
   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == oltkd_pkg::ST_INSERTED |-> rsp_entry_count != '0)
      else $error("insert reported an empty list");
`endif

endmodule

`default_nettype wire

// ===== design/oltkd_ram.sv =====
// ----------------------------------------------------------------------------
// oltkd_ram - generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module oltkd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/oltkd_dp.sv =====
// ----------------------------------------------------------------------------
// oltkd_dp - datapath of the ordered list unit
// Slot pool memories, head/tail/count registers, slot occupancy bits, walk
// pointer and the registered result port.
// ----------------------------------------------------------------------------
`default_nettype none

module oltkd_dp #(
   parameter int CAPACITY = oltkd_pkg::CAPACITY_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire oltkd_pkg::cmd_type                     cmd,
   output oltkd_pkg::sts_type                          sts,
   input  wire logic signed [oltkd_pkg::VALUE_W-1:0]   item_value,
   output logic                                        rsp_valid,
   output logic             [oltkd_pkg::STATUS_W-1:0]  rsp_status,
   output logic signed      [oltkd_pkg::VALUE_W-1:0]   rsp_result_value,
   output logic                                        rsp_last,
   output logic             [oltkd_pkg::COUNT_W-1:0]   rsp_entry_count
);

   localparam int IDX_W   = $clog2(CAPACITY);
   localparam int CNT_W   = $clog2(CAPACITY + 1);
   localparam int VALUE_W = oltkd_pkg::VALUE_W;
   localparam int COUNT_W = oltkd_pkg::COUNT_W;

   logic [VALUE_W-1:0]  key_ff, key_in;
   logic [IDX_W-1:0]    head_ff, head_in;
   logic [IDX_W-1:0]    tail_ff, tail_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CAPACITY-1:0] in_use_ff, in_use_in;
   logic [IDX_W-1:0]    scan_ff, scan_in;
   logic [IDX_W-1:0]    cur_ff, cur_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [oltkd_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [VALUE_W-1:0]           rsp_value_ff, rsp_value_in;
   logic                         rsp_last_ff, rsp_last_in;
   logic [COUNT_W-1:0]           rsp_count_ff, rsp_count_in;

   logic [VALUE_W-1:0] val_rd;
   logic [IDX_W-1:0]   fwd_rd, bwd_rd;
   logic [IDX_W-1:0]   rd_addr;
   logic               rd_en;
   logic               val_we, fwd_we, bwd_we;
   logic [IDX_W-1:0]   fwd_waddr, fwd_wdata, bwd_waddr, bwd_wdata;
   logic               is_head, is_tail;
   logic [CNT_W+COUNT_W-1:0] cnt_ext;

   oltkd_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_val_ram (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (scan_ff),
      .wr_data (key_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (val_rd)
   );

   oltkd_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_fwd_ram (
      .clock   (clock),
      .wr_en   (fwd_we),
      .wr_addr (fwd_waddr),
      .wr_data (fwd_wdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (fwd_rd)
   );

   oltkd_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_bwd_ram (
      .clock   (clock),
      .wr_en   (bwd_we),
      .wr_addr (bwd_waddr),
      .wr_data (bwd_wdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (bwd_rd)
   );

   assign is_head = (cur_ff == head_ff);
   assign is_tail = (cur_ff == tail_ff);
   assign cnt_ext = {COUNT_W'(0), count_ff};

   assign sts.count_zero = (count_ff == '0);
   assign sts.pool_full  = (count_ff == CNT_W'(CAPACITY));
   assign sts.slot_free  = !in_use_ff[scan_ff];
   assign sts.key_match  = (val_rd == key_ff);
   assign sts.walk_end   = ((idx_ff + CNT_W'(1)) == count_ff);

   // follow the forward link just read, or start at the head
   assign rd_en   = cmd.walk_start | cmd.walk_next;
   assign rd_addr = cmd.walk_next ? fwd_rd : head_ff;

   always_comb begin
      key_in    = key_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      in_use_in = in_use_ff;
      scan_in   = scan_ff;
      cur_in    = cur_ff;
      idx_in    = idx_ff;
      val_we    = 1'b0;
      fwd_we    = 1'b0;
      fwd_waddr = tail_ff;
      fwd_wdata = scan_ff;
      bwd_we    = 1'b0;
      bwd_waddr = scan_ff;
      bwd_wdata = tail_ff;

      if (cmd.load) begin
         key_in = item_value;
      end
      if (cmd.scan_clr) begin
         scan_in = '0;
      end
      if (cmd.scan_inc) begin
         scan_in = scan_ff + IDX_W'(1);
      end

      // link the new slot behind the tail
      if (cmd.append_wr) begin
         val_we    = 1'b1;
         bwd_we    = 1'b1;
         bwd_waddr = scan_ff;
         bwd_wdata = sts.count_zero ? '0 : tail_ff;
         fwd_we    = !sts.count_zero;
         fwd_waddr = tail_ff;
         fwd_wdata = scan_ff;
         head_in   = sts.count_zero ? scan_ff : head_ff;
         tail_in   = scan_ff;
         in_use_in[scan_ff] = 1'b1;
         count_in  = count_ff + CNT_W'(1);
      end

      if (cmd.walk_start) begin
         cur_in = head_ff;
         idx_in = '0;
      end
      if (cmd.walk_next) begin
         cur_in = fwd_rd;
         idx_in = idx_ff + CNT_W'(1);
      end

      // bridge the neighbors of the matched slot and free it
      if (cmd.unlink) begin
         if (!is_head) begin
            fwd_we    = 1'b1;
            fwd_waddr = bwd_rd;
            fwd_wdata = fwd_rd;
         end else begin
            head_in = fwd_rd;
         end
         if (!is_tail) begin
            bwd_we    = 1'b1;
            bwd_waddr = fwd_rd;
            bwd_wdata = bwd_rd;
         end else begin
            tail_in = bwd_rd;
         end
         in_use_in[cur_ff] = 1'b0;
         count_in = count_ff - CNT_W'(1);
         if (count_ff == CNT_W'(1)) begin
            head_in = '0;
            tail_in = '0;
         end
      end
   end

   always_comb begin
      rsp_valid_in  = cmd.emit;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_count_in  = rsp_count_ff;
      if (cmd.emit) begin
         rsp_status_in = cmd.emit_status;
         rsp_last_in   = cmd.emit_last;
         rsp_count_in  = cnt_ext[COUNT_W-1:0];
         case (cmd.emit_status)
            oltkd_pkg::ST_ELEMENT: rsp_value_in = val_rd;
            oltkd_pkg::ST_EMPTY:   rsp_value_in = '0;
            default:               rsp_value_in = key_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         in_use_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         in_use_ff    <= in_use_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      scan_ff       <= scan_in;
      cur_ff        <= cur_in;
      idx_ff        <= idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_last         = rsp_last_ff;
   assign rsp_entry_count  = rsp_count_ff;

endmodule

`default_nettype wire

// ===== design/oltkd_ctrl.sv =====
// ----------------------------------------------------------------------------
// oltkd_ctrl - controller of the ordered list unit
// Sequences free-slot scan, list walk, unlink and result strobes.
// ----------------------------------------------------------------------------
`default_nettype none

module oltkd_ctrl (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic [oltkd_pkg::OPCODE_W-1:0]    req_opcode,
   input  wire oltkd_pkg::sts_type                sts,
   output oltkd_pkg::cmd_type                     cmd,
   output logic                                   busy
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_EXEC   = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_WALK   = 3'd3;
   localparam logic [2:0] S_UNLINK = 3'd4;
   localparam logic [2:0] S_DONE   = 3'd5;

   logic [2:0]                     state_ff, state_in;
   logic [oltkd_pkg::OPCODE_W-1:0] op_ff, op_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      op_in    = op_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               op_in    = req_opcode;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            case (op_ff)
               oltkd_pkg::OP_APPEND: begin
                  if (sts.pool_full) begin
                     cmd.emit        = 1'b1;
                     cmd.emit_last   = 1'b1;
                     cmd.emit_status = oltkd_pkg::ST_FULL;
                     state_in        = S_IDLE;
                  end else begin
                     cmd.scan_clr = 1'b1;
                     state_in     = S_SCAN;
                  end
               end
               oltkd_pkg::OP_DELETE: begin
                  if (sts.count_zero) begin
                     cmd.emit        = 1'b1;
                     cmd.emit_last   = 1'b1;
                     cmd.emit_status = oltkd_pkg::ST_NOTFOUND;
                     state_in        = S_IDLE;
                  end else begin
                     cmd.walk_start = 1'b1;
                     state_in       = S_WALK;
                  end
               end
               oltkd_pkg::OP_READOUT: begin
                  if (sts.count_zero) begin
                     cmd.emit        = 1'b1;
                     cmd.emit_last   = 1'b1;
                     cmd.emit_status = oltkd_pkg::ST_EMPTY;
                     state_in        = S_IDLE;
                  end else begin
                     cmd.walk_start = 1'b1;
                     state_in       = S_WALK;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_SCAN: begin
            if (sts.slot_free) begin
               cmd.append_wr = 1'b1;
               state_in      = S_DONE;
            end else begin
               cmd.scan_inc = 1'b1;
            end
         end
         S_WALK: begin
            if (op_ff == oltkd_pkg::OP_READOUT) begin
               cmd.emit        = 1'b1;
               cmd.emit_last   = sts.walk_end;
               cmd.emit_status = oltkd_pkg::ST_ELEMENT;
               if (sts.walk_end) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.walk_next = 1'b1;
               end
            end else if (sts.key_match) begin
               state_in = S_UNLINK;
            end else if (sts.walk_end) begin
               cmd.emit        = 1'b1;
               cmd.emit_last   = 1'b1;
               cmd.emit_status = oltkd_pkg::ST_NOTFOUND;
               state_in        = S_IDLE;
            end else begin
               cmd.walk_next = 1'b1;
            end
         end
         S_UNLINK: begin
            cmd.unlink = 1'b1;
            state_in   = S_DONE;
         end
         S_DONE: begin
            cmd.emit        = 1'b1;
            cmd.emit_last   = 1'b1;
            cmd.emit_status = (op_ff == oltkd_pkg::OP_APPEND) ?
                              oltkd_pkg::ST_INSERTED : oltkd_pkg::ST_DELETED;
            state_in        = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
   end

   assign busy = (state_ff != S_IDLE);

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb - self-checking bench for the ordered list tail-insert / key-delete unit
// Drives appends, key deletes, read-outs and ignored opcodes through the
// start/busy command port. A queue-based copy of the list predicts every
// strobed result, and each result is checked field by field as it leaves.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
   import oltkd_pkg::*;

   localparam int LIST_CAP       = CAPACITY_DEF;
   localparam int RANDOM_ITEMS   = 100;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = LIST_CAP + 8;

   // The fourth opcode is not decoded: the unit takes it and does nothing.
   localparam logic [OPCODE_W-1:0] OP_NOP = 2'd3;

   typedef struct {
      logic [OPCODE_W-1:0]       op;
      logic signed [VALUE_W-1:0] value;
      int                        idle_pct;
   } list_command_type;

   typedef struct {
      logic [STATUS_W-1:0]       status;
      logic signed [VALUE_W-1:0] value;
      logic                      last;
      logic [COUNT_W-1:0]        count;
   } list_result_type;

   logic                       clock;
   logic                       reset          = 1'b1;
   logic                       start          = 1'b0;
   logic [OPCODE_W-1:0]        req_opcode     = OP_APPEND;
   logic signed [VALUE_W-1:0]  req_item_value = '0;
   logic                       busy;
   logic                       rsp_valid;
   logic [STATUS_W-1:0]        rsp_status;
   logic signed [VALUE_W-1:0]  rsp_result_value;
   logic                       rsp_last;
   logic [COUNT_W-1:0]         rsp_entry_count;

   // Commands waiting to be driven, filled once at time zero.
   list_command_type          command_queue[$];
   // List contents as the stimulus generator expects them to be; used only
   // to pick keys that hit and to steer the list between empty and full.
   logic signed [VALUE_W-1:0] planned_list[$];
   // Predicted list contents, head at index 0, updated at each transfer.
   logic signed [VALUE_W-1:0] list_contents[$];
   // Results predicted but not yet seen, oldest first.
   list_result_type           awaited_results[$];

   int unsigned err_count;
   int unsigned idle_cycles;
   int unsigned n_append, n_full, n_delete, n_miss, n_readout, n_empty, n_nop;
   int unsigned n_results, peak_entries;

   ordered_list_tail_insert_key_delete_unit #(
      .CAPACITY(LIST_CAP)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_opcode       (req_opcode),
      .req_item_value   (req_item_value),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_result_value (rsp_result_value),
      .rsp_last         (rsp_last),
      .rsp_entry_count  (rsp_entry_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hold reset high from time zero, then release it for the rest of the run.
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   // Queue a command and track its effect on the planned list. Return 1 when
   // the command is an append that will find the pool full.
   function automatic bit queue_list_command(input logic [OPCODE_W-1:0] op,
                                             input logic signed [VALUE_W-1:0] value,
                                             input int idle_pct);
      list_command_type cmd;
      bit               full_hit;
      cmd.op       = op;
      cmd.value    = value;
      cmd.idle_pct = idle_pct;
      command_queue.push_back(cmd);
      full_hit = 1'b0;
      if (op == OP_APPEND) begin
         if (planned_list.size() >= LIST_CAP) full_hit = 1'b1;
         else planned_list.push_back(value);
      end else if (op == OP_DELETE) begin
         for (int i = 0; i < planned_list.size(); i++) begin
            if (planned_list[i] == value) begin
               planned_list.delete(i);
               break;
            end
         end
      end
      return full_hit;
   endfunction

   function automatic void add_awaited(input logic [STATUS_W-1:0] status,
                                       input logic signed [VALUE_W-1:0] value,
                                       input logic last);
      list_result_type res;
      res.status = status;
      res.value  = value;
      res.last   = last;
      res.count  = COUNT_W'(list_contents.size());
      awaited_results.push_back(res);
   endfunction

   // Work out the results of one transferred command and advance the list.
   function automatic void predict_list_command(input logic [OPCODE_W-1:0] op,
                                                input logic signed [VALUE_W-1:0] value);
      int hit;
      hit = -1;
      case (op)
         OP_APPEND: begin
            n_append++;
            if (list_contents.size() >= LIST_CAP) begin
               // Full pool: nothing moves, the value is echoed back.
               n_full++;
               add_awaited(ST_FULL, value, 1'b1);
            end else begin
               list_contents.push_back(value);
               add_awaited(ST_INSERTED, value, 1'b1);
            end
         end
         OP_DELETE: begin
            n_delete++;
            // Only the first match counted from the head goes away.
            for (int i = 0; i < list_contents.size(); i++) begin
               if (list_contents[i] == value) begin
                  hit = i;
                  break;
               end
            end
            if (hit < 0) begin
               n_miss++;
               add_awaited(ST_NOTFOUND, value, 1'b1);
            end else begin
               list_contents.delete(hit);
               add_awaited(ST_DELETED, value, 1'b1);
            end
         end
         OP_READOUT: begin
            n_readout++;
            if (list_contents.size() == 0) begin
               n_empty++;
               add_awaited(ST_EMPTY, '0, 1'b1);
            end else begin
               for (int i = 0; i < list_contents.size(); i++)
                  add_awaited(ST_ELEMENT, list_contents[i], i == list_contents.size() - 1);
            end
         end
         default: begin
            n_nop++;
         end
      endcase
      if (list_contents.size() > peak_entries) peak_entries = list_contents.size();
   endfunction

   // Driver: a command transfers at an edge with start high and busy low.
   // While a command waits on busy, hold it. Otherwise either present the
   // next queued command or idle for this cycle, as the command's idle rate
   // says. Each input gets one assignment per edge so start stays high
   // across back-to-back commands.
   always @(posedge clock) begin : drive_proc
      list_command_type nxt;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) predict_list_command(req_opcode, req_item_value);
         if (start && busy) begin
            // hold the current command
         end else if (command_queue.size() != 0 &&
                      $urandom_range(99) >= command_queue[0].idle_pct) begin
            nxt = command_queue.pop_front();
            start          <= 1'b1;
            req_opcode     <= nxt.op;
            req_item_value <= nxt.value;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: take every strobed result and check it against the oldest
   // prediction; the unit cannot be stalled, so look at every edge.
   always @(posedge clock) begin : check_proc
      list_result_type want;
      if (!reset && rsp_valid) begin
         n_results++;
         if (awaited_results.size() == 0) begin
            $error("unexpected result: status %0d value %0d last %0d count %0d",
                   rsp_status, rsp_result_value, rsp_last, rsp_entry_count);
            err_count++;
         end else begin
            want = awaited_results.pop_front();
            if (rsp_status !== want.status) begin
               $error("rsp_status: expected %0d, got %0d", want.status, rsp_status);
               err_count++;
            end
            if (rsp_result_value !== want.value) begin
               $error("rsp_result_value: expected %0d, got %0d",
                      want.value, rsp_result_value);
               err_count++;
            end
            if (rsp_last !== want.last) begin
               $error("rsp_last: expected %0d, got %0d", want.last, rsp_last);
               err_count++;
            end
            if (rsp_entry_count !== want.count) begin
               $error("rsp_entry_count: expected %0d, got %0d",
                      want.count, rsp_entry_count);
               err_count++;
            end
         end
      end
   end

   // Watchdog: count cycles with neither a command nor a result transfer.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Stimulus: a directed opening, then random traffic that swings the list
   // between empty and full. Afterward drain and report.
   initial begin : stimulus_proc
      int                        idle;
      int                        sel;
      int                        rand_items;
      bit                        growing;
      logic signed [VALUE_W-1:0] v;

      // Empty list: read-out gives one empty result, a delete misses.
      void'(queue_list_command(OP_READOUT, '0, 35));
      void'(queue_list_command(OP_DELETE, 32'sd5, 35));
      // Field extremes, a duplicate, and alternating bit patterns.
      void'(queue_list_command(OP_APPEND, 32'sh7fff_ffff, 35));
      void'(queue_list_command(OP_APPEND, 32'sh8000_0000, 35));
      void'(queue_list_command(OP_APPEND, 32'sd0, 35));
      void'(queue_list_command(OP_APPEND, -32'sd1, 35));
      void'(queue_list_command(OP_APPEND, 32'sd0, 35));
      void'(queue_list_command(OP_APPEND, 32'sh5555_5555, 35));
      void'(queue_list_command(OP_APPEND, 32'shaaaa_aaaa, 35));
      void'(queue_list_command(OP_NOP, 32'sh1234_5678, 35));
      void'(queue_list_command(OP_READOUT, '0, 35));
      // Duplicate key: only the first zero goes. Then head, tail and a miss.
      void'(queue_list_command(OP_DELETE, 32'sd0, 35));
      void'(queue_list_command(OP_READOUT, '0, 35));
      void'(queue_list_command(OP_DELETE, 32'sh7fff_ffff, 35));
      void'(queue_list_command(OP_DELETE, 32'shaaaa_aaaa, 35));
      void'(queue_list_command(OP_DELETE, 32'sd1234, 35));
      void'(queue_list_command(OP_READOUT, '0, 35));
      // Empty the list; the last delete resets head and tail.
      void'(queue_list_command(OP_DELETE, 32'sh8000_0000, 35));
      void'(queue_list_command(OP_DELETE, -32'sd1, 35));
      void'(queue_list_command(OP_DELETE, 32'sd0, 35));
      void'(queue_list_command(OP_DELETE, 32'sh5555_5555, 35));
      void'(queue_list_command(OP_READOUT, '0, 35));
      // Reuse after emptying.
      void'(queue_list_command(OP_APPEND, 32'sd7, 35));
      void'(queue_list_command(OP_READOUT, '0, 35));
      void'(queue_list_command(OP_DELETE, 32'sd7, 35));

      // Random traffic: grow until an append bounces off the full pool,
      // then shrink until empty, and so on. Small values make duplicates.
      growing    = 1'b1;
      rand_items = 0;
      while (rand_items < RANDOM_ITEMS) begin
         idle = (rand_items < RANDOM_ITEMS / 3)     ? 35 :
                (rand_items < 2 * RANDOM_ITEMS / 3) ? 75 : 0;
         case ($urandom_range(9))
            0, 1, 2, 3: v = $signed($urandom_range(15)) - 8;
            4:          v = $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
            5:          v = $urandom_range(1) ? '0 : '1;
            default:    v = $urandom();
         endcase
         sel = $urandom_range(99);
         if (sel < 3) begin
            void'(queue_list_command(OP_NOP, v, idle));
         end else if (sel < (growing ? 76 : 18)) begin
            if (queue_list_command(OP_APPEND, v, idle)) growing = 1'b0;
            rand_items++;
         end else if (sel < (growing ? 90 : 86)) begin
            // Mostly aim at a stored value so deletes hit.
            if (planned_list.size() != 0 && $urandom_range(3) != 0)
               v = planned_list[$urandom_range(planned_list.size() - 1)];
            void'(queue_list_command(OP_DELETE, v, idle));
            if (planned_list.size() == 0) growing = 1'b1;
            rand_items++;
         end else begin
            void'(queue_list_command(OP_READOUT, v, idle));
            rand_items++;
         end
      end

      // Drain: wait for the last command to transfer and every predicted
      // result to arrive, then idle a walk's length to catch strays.
      @(negedge reset);
      do @(posedge clock); while (command_queue.size() != 0 || start);
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("tb: %0d appends (%0d full), %0d deletes (%0d misses), %0d read-outs (%0d empty)",
               n_append, n_full, n_delete, n_miss, n_readout, n_empty);
      $display("tb: %0d no-ops, %0d results checked, list peaked at %0d entries",
               n_nop, n_results, peak_entries);
      if (err_count == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/oltkd_pkg.sv
design/oltkd_ram.sv
design/oltkd_dp.sv
design/oltkd_ctrl.sv
design/ordered_list_tail_insert_key_delete_unit.sv
bench/tb.sv
